FILE: hw/rtl/lzfbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lzfbd_pkg
// Shared widths and constants of the flag-byte LZ decompressor.
// -----------------------------------------------------------------------------
package lzfbd_pkg;

    localparam int BYTE_W           = 8;
    localparam int WINDOW_DEPTH     = 4096;
    localparam int ADDR_W           = $clog2(WINDOW_DEPTH);
    localparam int PROD_W           = ADDR_W + 1;
    localparam int DIST_W           = ADDR_W + 1;
    localparam int MAX_RUN          = 256;
    localparam int LEN_W            = $clog2(MAX_RUN) + 1;
    localparam int BYTES_PER_RESULT = 4;
    localparam int SLOT_W           = $clog2(BYTES_PER_RESULT);
    localparam int CNT_W            = $clog2(BYTES_PER_RESULT) + 1;

    // token first-byte class bits
    localparam logic [BYTE_W-1:0] TOK_LONG  = 8'h80;
    localparam logic [BYTE_W-1:0] TOK_SHORT = 8'h40;
    localparam logic [BYTE_W-1:0] TOK_MID   = 8'h20;
    localparam logic [BYTE_W-1:0] TOK_FAR   = 8'h10;
    localparam logic [BYTE_W-1:0] TOK_RLE   = 8'd15;
    localparam logic [BYTE_W-1:0] TOK_END   = 8'd0;
    localparam logic [BYTE_W-1:0] FLAG_MARK = 8'h80;

endpackage

`default_nettype wire

FILE: hw/rtl/lzfbd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lzfbd_in_if
// Compressed byte channel: valid/ready with one data byte per beat.
// -----------------------------------------------------------------------------
interface lzfbd_in_if;

    logic                        valid;
    logic                        ready;
    logic [lzfbd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/lzfbd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lzfbd_out_if
// Decompressed result channel: up to four bytes plus status per beat.
// -----------------------------------------------------------------------------
interface lzfbd_out_if;

    logic                         valid;
    logic                         ready;
    logic [lzfbd_pkg::BYTE_W-1:0] out_byte0;
    logic [lzfbd_pkg::BYTE_W-1:0] out_byte1;
    logic [lzfbd_pkg::BYTE_W-1:0] out_byte2;
    logic [lzfbd_pkg::BYTE_W-1:0] out_byte3;
    logic [lzfbd_pkg::CNT_W-1:0]  byte_count;
    logic                         run_last;
    logic                         stream_end;
    logic                         reference_error;

    modport source (
        output valid, output out_byte0, output out_byte1, output out_byte2,
        output out_byte3, output byte_count, output run_last, output stream_end,
        output reference_error, input ready
    );
    modport sink (
        input valid, input out_byte0, input out_byte1, input out_byte2,
        input out_byte3, input byte_count, input run_last, input stream_end,
        input reference_error, output ready
    );

endinterface

`default_nettype wire

FILE: hw/rtl/lzfbd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lzfbd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// -----------------------------------------------------------------------------
module lzfbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lz_flag_byte_decompressor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lz_flag_byte_decompressor_top
// Flag-byte LZ77 decompressor with a 4096-byte history window.
// -----------------------------------------------------------------------------
// Usage:
//   i_in carries the compressed stream, one byte per beat. o_out carries
//   results of up to four decompressed bytes with byte_count, run_last (last
//   result of one input byte), stream_end and reference_error.
//   Flag bytes and leading token bytes give no result. A literal's result is
//   loaded into the output register in the cycle after its beat. A match runs
//   a copy sequencer over the history RAM: each byte takes a read state and
//   then a write state, and no new input byte is taken until the match is
//   done (a match is at most 256 bytes). A result is loaded every fourth
//   byte and at the last byte of the match.
//   i_in.ready is low while a copy runs and while a full output register is
//   stalled by the receiver; a stalled result holds and the copy pauses
//   until it is taken. The end token gives one result with byte_count zero
//   and restarts the parser with an empty window; RAM contents are kept.
//   Reset clears the parser and the output register; no clearing pass runs,
//   so the block accepts bytes right after reset.
// -----------------------------------------------------------------------------
module lz_flag_byte_decompressor_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lzfbd_in_if.sink   i_in,
    lzfbd_out_if.source o_out
);

    typedef enum logic [2:0] {
        PH_FLAG = 3'd0,
        PH_LIT  = 3'd1,
        PH_TOK1 = 3'd2,
        PH_TOK2 = 3'd3,
        PH_TOK3 = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE
    } t_seq;

    localparam int BW = lzfbd_pkg::BYTE_W;
    localparam int AW = lzfbd_pkg::ADDR_W;
    localparam int PW = lzfbd_pkg::PROD_W;
    localparam int DW = lzfbd_pkg::DIST_W;
    localparam int LW = lzfbd_pkg::LEN_W;
    localparam int SW = lzfbd_pkg::SLOT_W;
    localparam int CW = lzfbd_pkg::CNT_W;
    localparam int NB = lzfbd_pkg::BYTES_PER_RESULT;

    // parser and copy state
    t_seq            r_seq, n_seq;
    t_phase          r_phase, n_phase;
    logic [BW-1:0]   r_flag_shift, n_flag_shift;
    logic [BW-1:0]   r_tok_first, n_tok_first;
    logic [BW-1:0]   r_tok_second, n_tok_second;
    logic [AW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_prod, n_prod;
    logic [LW-1:0]   r_len, n_len;
    logic [DW-1:0]   r_dist, n_dist;
    logic            r_err, n_err;
    logic [SW-1:0]   r_slot, n_slot;
    logic [BW-1:0]   r_buf [NB];
    logic [BW-1:0]   n_buf [NB];

    // output register
    logic            r_ov, n_ov;
    logic [BW-1:0]   r_ob [NB];
    logic [BW-1:0]   n_ob [NB];
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_last, n_last;
    logic            r_end, n_end;
    logic            r_rerr, n_rerr;

    // history RAM port
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [BW-1:0]   ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [BW-1:0]   ram_rdata;

    logic            out_free;
    logic            in_acc;
    logic [BW-1:0]   b;
    logic [BW-1:0]   a;
    logic            start_match;
    logic [LW-1:0]   m_len;
    logic [DW-1:0]   m_dist;
    logic            next_bit;
    logic [BW-1:0]   next_fs;
    logic [BW-1:0]   cp_val;
    logic            cp_done;
    logic            cp_full;

    lzfbd_ram #(
        .WIDTH (BW),
        .DEPTH (lzfbd_pkg::WINDOW_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free    = !r_ov || o_out.ready;
    assign i_in.ready  = (r_seq == S_IDLE) && out_free;
    assign in_acc      = i_in.valid && i_in.ready;
    assign b           = i_in.data_byte;
    assign a           = r_tok_first;

    // item advance after a literal or a match
    assign next_bit = r_flag_shift[0];
    assign next_fs  = r_flag_shift >> 1;

    assign cp_val  = r_err ? '0 : ram_rdata;
    assign cp_done = (r_len == LW'(1));
    assign cp_full = (r_slot == SW'(NB - 1)) || cp_done;

    assign o_out.valid           = r_ov;
    assign o_out.out_byte0       = r_ob[0];
    assign o_out.out_byte1       = r_ob[1];
    assign o_out.out_byte2       = r_ob[2];
    assign o_out.out_byte3       = r_ob[3];
    assign o_out.byte_count      = r_cnt;
    assign o_out.run_last        = r_last;
    assign o_out.stream_end      = r_end;
    assign o_out.reference_error = r_rerr;

    // token decode for the beat that completes a match
    always_comb begin
        start_match = 1'b0;
        m_len       = '0;
        m_dist      = '0;
        unique case (r_phase)
            PH_TOK1: begin
                if (b != lzfbd_pkg::TOK_END && (b & lzfbd_pkg::TOK_LONG) == '0) begin
                    if ((b & lzfbd_pkg::TOK_SHORT) != '0) begin
                        start_match = 1'b1;
                        m_len       = LW'(2);
                        m_dist      = DW'(b[5:0]) + DW'(1);
                    end else if ((b & (lzfbd_pkg::TOK_MID | lzfbd_pkg::TOK_FAR)) == '0
                                 && b != lzfbd_pkg::TOK_RLE) begin
                        start_match = 1'b1;
                        m_len       = (b > BW'(1)) ? LW'(b) : LW'(lzfbd_pkg::MAX_RUN);
                        m_dist      = DW'(m_len);
                    end
                end
            end
            PH_TOK2: begin
                if ((a & lzfbd_pkg::TOK_LONG) != '0) begin
                    start_match = 1'b1;
                    m_len       = LW'(3) + LW'(a[6:4]);
                    m_dist      = DW'({a[3:0], b}) + DW'(1);
                end else if ((a & lzfbd_pkg::TOK_MID) != '0) begin
                    start_match = 1'b1;
                    m_len       = LW'(2) + LW'(a[4:0]);
                    m_dist      = DW'(b) + DW'(1);
                end else if ((a & lzfbd_pkg::TOK_FAR) == '0) begin
                    start_match = 1'b1;
                    m_len       = LW'(b) + LW'(1);
                    m_dist      = DW'(m_len);
                end
            end
            PH_TOK3: begin
                start_match = 1'b1;
                m_len       = LW'(b) + LW'(1);
                m_dist      = DW'({a[3:0], r_tok_second}) + DW'(1);
            end
            default: begin
                start_match = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_seq        = r_seq;
        n_phase      = r_phase;
        n_flag_shift = r_flag_shift;
        n_tok_first  = r_tok_first;
        n_tok_second = r_tok_second;
        n_wp         = r_wp;
        n_prod       = r_prod;
        n_len        = r_len;
        n_dist       = r_dist;
        n_err        = r_err;
        n_slot       = r_slot;
        n_buf        = r_buf;
        n_ov         = r_ov && !o_out.ready;
        n_ob         = r_ob;
        n_cnt        = r_cnt;
        n_last       = r_last;
        n_end        = r_end;
        n_rerr       = r_rerr;
        ram_we       = 1'b0;
        ram_waddr    = r_wp;
        ram_wdata    = b;
        ram_re       = 1'b0;
        ram_raddr    = r_wp - r_dist[AW-1:0];

        unique case (r_seq)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (r_phase)
                        PH_LIT: begin
                            ram_we   = 1'b1;
                            n_wp     = r_wp + AW'(1);
                            if (r_prod != PW'(lzfbd_pkg::WINDOW_DEPTH)) begin
                                n_prod = r_prod + PW'(1);
                            end
                            n_ov     = 1'b1;
                            n_ob[0]  = b;
                            n_ob[1]  = '0;
                            n_ob[2]  = '0;
                            n_ob[3]  = '0;
                            n_cnt    = CW'(1);
                            n_last   = 1'b1;
                            n_end    = 1'b0;
                            n_rerr   = 1'b0;
                        end
                        PH_TOK1: begin
                            n_tok_first = b;
                            if (b == lzfbd_pkg::TOK_END) begin
                                n_ov         = 1'b1;
                                n_ob[0]      = '0;
                                n_ob[1]      = '0;
                                n_ob[2]      = '0;
                                n_ob[3]      = '0;
                                n_cnt        = '0;
                                n_last       = 1'b1;
                                n_end        = 1'b1;
                                n_rerr       = 1'b0;
                                n_tok_first  = '0;
                                n_tok_second = '0;
                                n_wp         = '0;
                                n_prod       = '0;
                            end else if (!start_match) begin
                                n_phase = PH_TOK2;
                            end
                        end
                        PH_TOK2: begin
                            n_tok_second = b;
                            if (!start_match) begin
                                n_phase = PH_TOK3;
                            end
                        end
                        PH_TOK3: begin
                            n_phase = PH_TOK3;
                        end
                        default: begin
                            // flag byte: sentinel bit counts the eight items
                            n_flag_shift = (b >> 1) | lzfbd_pkg::FLAG_MARK;
                            n_phase      = b[0] ? PH_TOK1 : PH_LIT;
                        end
                    endcase

                    if (r_phase == PH_TOK1 && b == lzfbd_pkg::TOK_END) begin
                        n_flag_shift = '0;
                        n_phase      = PH_FLAG;
                    end else if (r_phase == PH_LIT || start_match) begin
                        n_flag_shift = next_fs;
                        if (next_fs == '0) begin
                            n_phase = PH_FLAG;
                        end else begin
                            n_phase = next_bit ? PH_TOK1 : PH_LIT;
                        end
                    end

                    if (start_match) begin
                        n_seq  = S_READ;
                        n_len  = m_len;
                        n_dist = m_dist;
                        n_err  = m_dist > r_prod;
                        n_slot = '0;
                    end
                end
            end
            S_READ: begin
                ram_re = 1'b1;
                n_seq  = S_WRITE;
            end
            S_WRITE: begin
                // hold while a full result cannot be handed over
                if (!cp_full || out_free) begin
                    ram_we    = 1'b1;
                    ram_wdata = cp_val;
                    n_wp      = r_wp + AW'(1);
                    if (r_prod != PW'(lzfbd_pkg::WINDOW_DEPTH)) begin
                        n_prod = r_prod + PW'(1);
                    end
                    if (r_slot == '0) begin
                        n_buf[0] = '0;
                        n_buf[1] = '0;
                        n_buf[2] = '0;
                        n_buf[3] = '0;
                    end
                    n_buf[r_slot] = cp_val;
                    n_slot        = r_slot + SW'(1);
                    n_len         = r_len - LW'(1);
                    if (cp_full) begin
                        n_ov   = 1'b1;
                        n_ob   = n_buf;
                        n_cnt  = CW'(r_slot) + CW'(1);
                        n_last = cp_done;
                        n_end  = 1'b0;
                        n_rerr = r_err;
                    end
                    n_seq = cp_done ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_seq = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= S_IDLE;
            r_phase      <= PH_FLAG;
            r_flag_shift <= '0;
            r_tok_first  <= '0;
            r_tok_second <= '0;
            r_wp         <= '0;
            r_prod       <= '0;
            r_len        <= '0;
            r_dist       <= '0;
            r_err        <= 1'b0;
            r_slot       <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_seq        <= n_seq;
            r_phase      <= n_phase;
            r_flag_shift <= n_flag_shift;
            r_tok_first  <= n_tok_first;
            r_tok_second <= n_tok_second;
            r_wp         <= n_wp;
            r_prod       <= n_prod;
            r_len        <= n_len;
            r_dist       <= n_dist;
            r_err        <= n_err;
            r_slot       <= n_slot;
            r_ov         <= n_ov;
        end
        r_buf  <= n_buf;
        r_ob   <= n_ob;
        r_cnt  <= n_cnt;
        r_last <= n_last;
        r_end  <= n_end;
        r_rerr <= n_rerr;
    end

`ifndef SYNTHESIS
    a_prod_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod <= PW'(lzfbd_pkg::WINDOW_DEPTH))
        else $error("produced count above window depth");

    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_READ || r_seq == S_WRITE) |-> r_len != '0)
        else $error("copy running with zero bytes left");

    a_zero_cnt_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_cnt == '0) |-> r_end)
        else $error("empty result without end of stream");

    a_tok3_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_TOK3) |=> r_seq == S_READ)
        else $error("third token byte did not start a copy");

    a_err_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_rerr) |-> (r_ob[0] == '0 && r_ob[1] == '0
                              && r_ob[2] == '0 && r_ob[3] == '0))
        else $error("reference error result carries data");
`endif

endmodule

`default_nettype wire

FILE: tb/lz_flag_byte_decompressor_top_test.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lz_flag_byte_decompressor_top_test
// Drives compressed byte streams into the decompressor: a short directed
// stream with every token class and out-of-window copies, a window fill that
// saturates the history, then random flag groups with mostly well-formed
// tokens. A predictor decodes each accepted byte and every output beat is
// compared field by field. Both channels idle and stall at random.
// -----------------------------------------------------------------------------
module lz_flag_byte_decompressor_top_test;

    localparam int BYTE_W           = lzfbd_pkg::BYTE_W;
    localparam int WINDOW_DEPTH     = lzfbd_pkg::WINDOW_DEPTH;
    localparam int ADDR_W           = lzfbd_pkg::ADDR_W;
    localparam int MAX_RUN          = lzfbd_pkg::MAX_RUN;
    localparam int BYTES_PER_RESULT = lzfbd_pkg::BYTES_PER_RESULT;
    localparam int CNT_W            = lzfbd_pkg::CNT_W;

    localparam logic [BYTE_W-1:0] TOK_LONG  = lzfbd_pkg::TOK_LONG;
    localparam logic [BYTE_W-1:0] TOK_SHORT = lzfbd_pkg::TOK_SHORT;
    localparam logic [BYTE_W-1:0] TOK_MID   = lzfbd_pkg::TOK_MID;
    localparam logic [BYTE_W-1:0] TOK_FAR   = lzfbd_pkg::TOK_FAR;
    localparam logic [BYTE_W-1:0] TOK_RLE   = lzfbd_pkg::TOK_RLE;
    localparam logic [BYTE_W-1:0] TOK_END   = lzfbd_pkg::TOK_END;

    localparam int RANDOM_BYTES = 460;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 600;
    localparam int REPORT_MAX   = 10;

    typedef enum logic [2:0] {
        AWAIT_FLAG,
        AWAIT_LITERAL,
        AWAIT_TOKEN_A,
        AWAIT_TOKEN_B,
        AWAIT_TOKEN_C
    } t_parse_state;

    typedef struct packed {
        logic [BYTES_PER_RESULT-1:0][BYTE_W-1:0] data;
        logic [CNT_W-1:0]                        count;
        logic                                    last;
        logic                                    ends;
        logic                                    ref_err;
    } t_out_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lzfbd_in_if  in_ch ();
    lzfbd_out_if out_ch ();

    lz_flag_byte_decompressor_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // stimulus and decoded output
    logic [BYTE_W-1:0] compressed_q [$];
    t_out_beat         decoded_q [$];

    // decoder state mirror
    logic [BYTE_W-1:0] flag_bits;
    t_parse_state      parse_state;
    logic [BYTE_W-1:0] tok_a;
    logic [BYTE_W-1:0] tok_b;
    logic [BYTE_W-1:0] history [WINDOW_DEPTH];
    logic [ADDR_W-1:0] wr_ptr;
    int                produced;

    // stream generation tracks how much history is valid
    int gen_avail;

    int fail_count;
    int bytes_taken;
    int beats_checked;
    int err_beats;
    int end_beats;
    int idle_cycles;
    int send_gap;
    int hold_cnt;
    bit in_calm;
    bit out_calm;

    // ---------------------------------------------------------------- decoder

    task automatic next_item();
        logic bit0;
        bit0 = flag_bits[0];
        flag_bits = flag_bits >> 1;
        if (flag_bits == '0) begin
            parse_state = AWAIT_FLAG;
        end else begin
            parse_state = bit0 ? AWAIT_TOKEN_A : AWAIT_LITERAL;
        end
    endtask

    task automatic record_byte(logic [BYTE_W-1:0] v);
        history[wr_ptr] = v;
        wr_ptr = wr_ptr + 1'b1;
        if (produced < WINDOW_DEPTH) produced++;
    endtask

    task automatic decode_copy(int len, int distance);
        t_out_beat         r;
        logic              err;
        logic [BYTE_W-1:0] v;
        int                slot;
        err = distance > produced;
        r = '0;
        for (int i = 0; i < len; i++) begin
            slot = i % BYTES_PER_RESULT;
            if (slot == 0) r = '0;
            v = err ? '0 : history[wr_ptr - ADDR_W'(distance)];
            record_byte(v);
            r.data[slot] = v;
            r.count = CNT_W'(slot + 1);
            r.ref_err = err;
            if (slot == BYTES_PER_RESULT - 1 || i + 1 == len) begin
                r.last = (i + 1 == len);
                decoded_q.push_back(r);
            end
        end
        next_item();
    endtask

    task automatic decode_byte(logic [BYTE_W-1:0] b);
        t_out_beat r;
        r = '0;
        case (parse_state)
            AWAIT_LITERAL: begin
                r.data[0] = b;
                r.count = CNT_W'(1);
                r.last = 1'b1;
                decoded_q.push_back(r);
                record_byte(b);
                next_item();
            end
            AWAIT_TOKEN_A: begin
                tok_a = b;
                if (b == TOK_END) begin
                    r.last = 1'b1;
                    r.ends = 1'b1;
                    decoded_q.push_back(r);
                    flag_bits = '0;
                    parse_state = AWAIT_FLAG;
                    tok_a = '0;
                    tok_b = '0;
                    wr_ptr = '0;
                    produced = 0;
                end else if ((b & TOK_LONG) != '0) begin
                    parse_state = AWAIT_TOKEN_B;
                end else if ((b & TOK_SHORT) != '0) begin
                    decode_copy(2, int'(b[5:0]) + 1);
                end else if ((b & (TOK_MID | TOK_FAR)) != '0 || b == TOK_RLE) begin
                    parse_state = AWAIT_TOKEN_B;
                end else begin
                    decode_copy(b > 8'd1 ? int'(b) : MAX_RUN, b > 8'd1 ? int'(b) : MAX_RUN);
                end
            end
            AWAIT_TOKEN_B: begin
                tok_b = b;
                if ((tok_a & TOK_LONG) != '0) begin
                    decode_copy(3 + int'(tok_a[6:4]), int'({tok_a[3:0], b}) + 1);
                end else if ((tok_a & TOK_MID) != '0) begin
                    decode_copy(2 + int'(tok_a[4:0]), int'(b) + 1);
                end else if ((tok_a & TOK_FAR) != '0) begin
                    parse_state = AWAIT_TOKEN_C;
                end else begin
                    decode_copy(int'(b) + 1, int'(b) + 1);
                end
            end
            AWAIT_TOKEN_C: begin
                decode_copy(int'(b) + 1, int'({tok_a[3:0], tok_b}) + 1);
            end
            default: begin
                flag_bits = {1'b1, b[7:1]};
                parse_state = b[0] ? AWAIT_TOKEN_A : AWAIT_LITERAL;
            end
        endcase
    endtask

    // ------------------------------------------------------- stream generator

    task automatic push_byte(logic [BYTE_W-1:0] b);
        compressed_q.push_back(b);
    endtask

    task automatic note_output(int n);
        gen_avail = (gen_avail + n > WINDOW_DEPTH) ? WINDOW_DEPTH : gen_avail + n;
    endtask

    // mostly a distance inside the valid history, now and then anything
    function automatic int pick_dist(int maxd, bit allow_bad);
        int top;
        top = (gen_avail < maxd) ? gen_avail : maxd;
        if (top == 0 || (allow_bad && $urandom_range(0, 7) == 0))
            return int'($urandom_range(1, maxd));
        return int'($urandom_range(1, top));
    endfunction

    task automatic emit_far(int distance, int len);
        push_byte(TOK_FAR | BYTE_W'((distance - 1) >> 8));
        push_byte(BYTE_W'(distance - 1));
        push_byte(BYTE_W'(len - 1));
        note_output(len);
    endtask

    task automatic gen_token(output bit ended);
        int                pick;
        int                len;
        int                distance;
        logic [BYTE_W-1:0] a;
        ended = 1'b0;
        pick = int'($urandom_range(0, 99));
        if (pick < 12) begin
            len = int'($urandom_range(3, 10));
            distance = pick_dist(WINDOW_DEPTH, 1'b1);
            push_byte(TOK_LONG | BYTE_W'((len - 3) << 4) | BYTE_W'((distance - 1) >> 8));
            push_byte(BYTE_W'(distance - 1));
            note_output(len);
        end else if (pick < 24) begin
            distance = pick_dist(64, 1'b1);
            push_byte(TOK_SHORT | BYTE_W'(distance - 1));
            note_output(2);
        end else if (pick < 40) begin
            len = int'($urandom_range(2, 33));
            distance = pick_dist(256, 1'b1);
            push_byte(TOK_MID | BYTE_W'(len - 2));
            push_byte(BYTE_W'(distance - 1));
            note_output(len);
        end else if (pick < 56) begin
            distance = pick_dist(WINDOW_DEPTH, 1'b1);
            len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 256))
                                               : int'($urandom_range(1, 24));
            emit_far(distance, len);
        end else if (pick < 66) begin
            len = pick_dist(256, 1'b1);
            push_byte(TOK_RLE);
            push_byte(BYTE_W'(len - 1));
            note_output(len);
        end else if (pick < 78) begin
            len = pick_dist(14, 1'b1);
            if (len < 2) len = 2;
            push_byte(BYTE_W'(len));
            note_output(len);
        end else if (pick < 81) begin
            push_byte(BYTE_W'(1));
            note_output(MAX_RUN);
        end else if (pick < 95) begin
            // random first byte, followed by as many bytes as its class takes
            a = BYTE_W'($urandom_range(0, 255));
            push_byte(a);
            if (a == TOK_END) begin
                ended = 1'b1;
                gen_avail = 0;
            end else if (a[7] || (!a[6] && (a[5] || a == TOK_RLE))) begin
                push_byte(BYTE_W'($urandom_range(0, 255)));
            end else if (!a[6] && a[4]) begin
                push_byte(BYTE_W'($urandom_range(0, 255)));
                push_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end else begin
            push_byte(TOK_END);
            ended = 1'b1;
            gen_avail = 0;
        end
    endtask

    task automatic gen_group();
        logic [BYTE_W-1:0] flag;
        bit                ended;
        ended = 1'b0;
        flag = BYTE_W'($urandom_range(0, 255));
        push_byte(flag);
        for (int i = 0; i < 8 && !ended; i++) begin
            if (!flag[i]) begin
                push_byte(BYTE_W'($urandom_range(0, 255)));
                note_output(1);
            end else begin
                gen_token(ended);
            end
        end
    endtask

    // ------------------------------------------------------------------ driver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= '0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                decode_byte(in_ch.data_byte);
                bytes_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (compressed_q.size() > 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= compressed_q.pop_front();
                    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
                    send_gap = in_calm ? 0 : int'($urandom_range(0, 3));
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ----------------------------------------------------------------- monitor

    task automatic report_mismatch(string field, int want, int got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("MISMATCH beat %0d %s: expected %0d, got %0d",
                     beats_checked, field, want, got);
    endtask

    task automatic check_beat();
        t_out_beat want;
        t_out_beat got;
        got.data = {out_ch.out_byte3, out_ch.out_byte2, out_ch.out_byte1,
                    out_ch.out_byte0};
        got.count = out_ch.byte_count;
        got.last = out_ch.run_last;
        got.ends = out_ch.stream_end;
        got.ref_err = out_ch.reference_error;
        if (decoded_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("UNEXPECTED beat: count %0d bytes %h", got.count, got.data);
        end else begin
            want = decoded_q.pop_front();
            for (int k = 0; k < BYTES_PER_RESULT; k++)
                if (got.data[k] !== want.data[k])
                    report_mismatch($sformatf("out_byte%0d", k), want.data[k], got.data[k]);
            if (got.count !== want.count)
                report_mismatch("byte_count", want.count, got.count);
            if (got.last !== want.last)
                report_mismatch("run_last", want.last, got.last);
            if (got.ends !== want.ends)
                report_mismatch("stream_end", want.ends, got.ends);
            if (got.ref_err !== want.ref_err)
                report_mismatch("reference_error", want.ref_err, got.ref_err);
            if (want.ref_err) err_beats++;
            if (want.ends) end_beats++;
        end
        beats_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_beat();
                if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
                hold_cnt = out_calm ? 0 : int'($urandom_range(0, 3));
            end else if (hold_cnt > 0) begin
                hold_cnt--;
            end
            out_ch.ready <= (hold_cnt == 0);
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("no progress for %0d cycles, %0d bytes left to send, %0d beats outstanding",
                 IDLE_LIMIT, compressed_q.size(), decoded_q.size());
        $display("lz_flag_byte_decompressor_top_test failed");
        $finish;
    end

    // --------------------------------------------------------------- sequence

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        out_ch.ready = 1'b0;
        idle_cycles = 0;
        fail_count = 0;
        bytes_taken = 0;
        beats_checked = 0;
        err_beats = 0;
        end_beats = 0;
        in_calm = 1'b0;
        out_calm = 1'b0;
        flag_bits = '0;
        parse_state = AWAIT_FLAG;
        tok_a = '0;
        tok_b = '0;
        wr_ptr = '0;
        produced = 0;

        // directed stream: two literals, then every token class
        push_byte(8'hFC);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h41);                                   // short, distance 2
        push_byte(8'h02);                                   // small run of 2
        push_byte(TOK_RLE);  push_byte(8'h03);              // run of 4
        push_byte(TOK_MID);  push_byte(8'h00);              // overlap, distance 1
        push_byte(TOK_FAR);  push_byte(8'h00); push_byte(8'h04);
        push_byte(TOK_LONG); push_byte(8'h00);
        // out-of-window copies, then the end token
        push_byte(8'h0F);
        push_byte(8'hFF);    push_byte(8'hFF);              // long, distance 4096
        push_byte(8'h7F);                                   // short, distance 64
        push_byte(8'h01);                                   // full 256-byte run
        push_byte(TOK_END);
        gen_avail = 0;

        // fill the whole window so later copies can reach back 4096 bytes
        push_byte(8'h00);
        for (int i = 0; i < 8; i++) begin
            push_byte(BYTE_W'($urandom_range(0, 255)));
            note_output(1);
        end
        for (int g = 0; g < 3; g++) begin
            push_byte(8'hFF);
            for (int i = 0; i < 8; i++)
                emit_far(int'($urandom_range(1, gen_avail)), MAX_RUN);
        end

        while (compressed_q.size() < RANDOM_BYTES) gen_group();
        // parser sits at a flag boundary here; close the stream
        push_byte(8'h01);
        push_byte(TOK_END);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (compressed_q.size() != 0 || in_ch.valid || decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            fail_count++;
            $display("%0d decoded beats never arrived", decoded_q.size());
        end

        $display("Sent %0d compressed bytes and checked %0d output beats", bytes_taken,
                 beats_checked);
        $display("  of them %0d out-of-window beats and %0d end-of-stream beats; %0d errors",
                 err_beats, end_beats, fail_count);
        if (fail_count == 0) begin
            $display("lz_flag_byte_decompressor_top_test passed");
        end else begin
            $display("lz_flag_byte_decompressor_top_test failed");
        end
        $finish;
    end

endmodule
